### hdl/lin_diag_transport_layer_unit_defines.svh
// Assertion macros for the LIN diagnostic transport layer checker
`ifndef LIN_DIAG_TRANSPORT_LAYER_UNIT_DEFINES_SVH
`define LIN_DIAG_TRANSPORT_LAYER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LDT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lin_dtl_pkg.sv
// Package: types and constants of the LIN diagnostic transport layer
`timescale 1ns / 1ps
package lin_dtl_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned SF_MAX = 6;
  localparam int unsigned FF_BYTES = 5;

  localparam logic [7:0] NAD_BROADCAST = 8'h7F;
  localparam logic [7:0] NAD_FUNCTIONAL = 8'h7E;
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  localparam logic [7:0] RST_NAD = 8'h01;
  localparam logic [15:0] RST_TIMEOUT = 16'd1000;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WAIT_CF = 3'd1,
    MODE_SEND_SF = 3'd2,
    MODE_SEND_FF = 3'd3,
    MODE_SEND_CF = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REQ_RX_FRAME = 3'd0,
    REQ_LOAD     = 3'd1,
    REQ_TX_SLOT  = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_READ     = 3'd4
  } req_e;

  typedef enum logic [7:0] {
    CFG_CONFIGURED_NAD = 8'd0,
    CFG_INITIAL_NAD    = 8'd1,
    CFG_RESPONSE_NAD   = 8'd2,
    CFG_RX_TIMEOUT     = 8'd3,
    CFG_SEP_TIME       = 8'd4
  } cfg_idx_e;

endpackage

### hdl/lin_dtl_req_if.sv
// Interface: request channel
`timescale 1ns / 1ps
interface lin_dtl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] frame;
  logic [7:0]  resp_byte;
  logic [11:0] byte_index;
  logic [11:0] resp_length;
  logic        resp_last;
  modport source (output valid, req_type, frame, resp_byte, byte_index, resp_length,
                  resp_last, input ready);
  modport sink (input valid, req_type, frame, resp_byte, byte_index, resp_length,
                resp_last, output ready);
endinterface

### hdl/lin_dtl_rsp_if.sv
// Interface: result channel
`timescale 1ns / 1ps
interface lin_dtl_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [63:0] tx_frame;
  logic        msg_complete;
  logic [7:0]  msg_nad;
  logic [11:0] msg_length;
  logic [7:0]  read_byte;
  logic [2:0]  tl_mode;
  logic        aborted;
  modport source (output valid, tx_valid, tx_frame, msg_complete, msg_nad, msg_length,
                  read_byte, tl_mode, aborted, input ready);
  modport sink (input valid, tx_valid, tx_frame, msg_complete, msg_nad, msg_length,
                read_byte, tl_mode, aborted, output ready);
endinterface

### hdl/lin_dtl_cfg_if.sv
// Interface: configuration write channel
`timescale 1ns / 1ps
interface lin_dtl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/lin_dtl_mem.sv
// Message buffer: one write port, one registered read port
`timescale 1ns / 1ps
module lin_dtl_mem #(
  parameter int unsigned DEPTH = lin_dtl_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### hdl/lin_diag_transport_layer_unit.sv
// Top level: LIN diagnostic transport layer, slave side
// Channels: req_i takes one request beat (received frame, response byte load, transmit
// slot, millisecond tick or host read); rsp_o returns exactly one result beat for each;
// cfg_i writes the five registers by index and is always ready.
// Sequence: a request beat is decoded in S_EXEC, then S_MOVE moves its buffer bytes one per
// cycle through the single memory port (up to six for a frame, one for a load or read) and
// drains the registered read data; S_DONE then puts the result in the output register.
// Flow: one request at a time; req_i is ready again once the result sits in the output
// register, so the byte-moving sequencer on the buffer port sets the pace of new requests.
// Reset: the layer returns to idle; its position, length, sequence and timer counters
// clear and the configuration registers take their reset values; buffer contents are
// undefined until written and need no clearing.
// Stall: a result held by rsp_o waits in the output register; the next request may be
// accepted and worked on, and its result waits until the held one is taken.
`timescale 1ns / 1ps
module lin_diag_transport_layer_unit #(
  parameter int unsigned BUFFER_DEPTH = lin_dtl_pkg::BUFFER_DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  lin_dtl_req_if.sink  req_i,
  lin_dtl_rsp_if.source rsp_o,
  lin_dtl_cfg_if.sink  cfg_i
);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [11:0] DEPTH12 = 12'(BUFFER_DEPTH);
  localparam logic [12:0] DEPTH13 = 13'(BUFFER_DEPTH);
  localparam logic [11:0] SF12 = 12'(lin_dtl_pkg::SF_MAX);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MOVE, S_DONE} state_e;
  state_e state_q;

  logic [7:0]  cfg_nad_q, init_nad_q, resp_nad_q, sep_time_q;
  logic [15:0] rx_to_q;

  logic [2:0]  req_q;
  logic [63:0] frame_q;
  logic [7:0]  rbyte_q;
  logic [11:0] bidx_q, rlen_q;
  logic        rlast_q;

  lin_dtl_pkg::mode_e mode_q, mode_d;
  logic [11:0] pos_q, pos_d, tl_q, tl_d;
  logic [3:0]  seq_q, seq_d;
  logic [15:0] to_q, to_d;
  logic        armed_q, armed_d;
  logic [7:0]  sep_q, sep_d;

  logic        wr_q, wr_d, rd_q, rd_d, host_q, host_d;
  logic [2:0]  cnt_q, cnt_d, k_q;
  logic [12:0] base_q, base_d;
  logic [63:0] wsh_q, wsh_d;
  logic [2:0]  slot_q, slot_d, rslot_q;
  logic        rv_q;
  logic        txv_q, txv_d, done_q, done_d, ab_q, ab_d;
  logic [63:0] txf_q, txf_d;
  logic [7:0]  dnad_q, dnad_d, rdb_q;

  logic [7:0]  nad, b1;
  logic [11:0] ff_len, rem12, sf_len;
  logic [2:0]  rem;
  logic [15:0] to_dec;
  logic        lay_rst;
  logic [7:0]  sep_base;

  logic [12:0] addr;
  logic        inr, step;
  logic        mem_we, mem_re;
  logic [7:0]  mem_rdata;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign nad = frame_q[7:0];
  assign b1 = frame_q[15:8];
  assign ff_len = {b1[3:0], frame_q[23:16]};
  assign rem12 = (tl_q > pos_q) ? (tl_q - pos_q) : 12'd0;
  assign rem = (rem12 > SF12) ? 3'(lin_dtl_pkg::SF_MAX) : rem12[2:0];
  assign sf_len = (tl_q > SF12) ? SF12 : tl_q;
  assign to_dec = to_q - 16'd1;

  always_comb begin
    mode_d = mode_q;
    pos_d = pos_q;
    tl_d = tl_q;
    seq_d = seq_q;
    to_d = to_q;
    armed_d = armed_q;
    sep_d = sep_q;
    wr_d = 1'b0;
    rd_d = 1'b0;
    host_d = 1'b0;
    cnt_d = 3'd0;
    base_d = 13'd0;
    wsh_d = frame_q >> 16;
    slot_d = 3'd2;
    txv_d = 1'b0;
    txf_d = '1;
    done_d = 1'b0;
    dnad_d = 8'd0;
    ab_d = 1'b0;
    lay_rst = 1'b0;
    sep_base = sep_q;
    case (req_q)
      lin_dtl_pkg::REQ_RX_FRAME: begin
        if (nad != lin_dtl_pkg::NAD_BROADCAST && nad != lin_dtl_pkg::NAD_FUNCTIONAL &&
            nad != cfg_nad_q && nad != init_nad_q) begin
          lay_rst = 1'b1;
          ab_d = 1'b1;
        end else if (mode_q != lin_dtl_pkg::MODE_IDLE &&
                     nad == lin_dtl_pkg::NAD_FUNCTIONAL) begin
          armed_d = 1'b1;
          to_d = rx_to_q;
        end else if (b1[7:4] == lin_dtl_pkg::PCI_SINGLE) begin
          if (b1[3:0] >= 4'd1 && b1[3:0] <= 4'(lin_dtl_pkg::SF_MAX)) begin
            wr_d = 1'b1;
            cnt_d = b1[2:0];
            tl_d = {8'd0, b1[3:0]};
            mode_d = lin_dtl_pkg::MODE_IDLE;
            armed_d = 1'b0;
            done_d = 1'b1;
            dnad_d = nad;
          end
        end else if (b1[7:4] == lin_dtl_pkg::PCI_FIRST) begin
          if (ff_len > SF12 && ff_len <= DEPTH12) begin
            tl_d = ff_len;
            wr_d = 1'b1;
            cnt_d = 3'(lin_dtl_pkg::FF_BYTES);
            wsh_d = frame_q >> 24;
            pos_d = 12'(lin_dtl_pkg::FF_BYTES);
            seq_d = 4'd1;
            mode_d = lin_dtl_pkg::MODE_WAIT_CF;
            armed_d = 1'b1;
            to_d = rx_to_q;
          end
        end else if (b1[7:4] == lin_dtl_pkg::PCI_CONSEC) begin
          if (mode_q == lin_dtl_pkg::MODE_WAIT_CF) begin
            if (b1[3:0] != seq_q) begin
              lay_rst = 1'b1;
              ab_d = 1'b1;
            end else begin
              wr_d = 1'b1;
              cnt_d = rem;
              base_d = {1'b0, pos_q};
              pos_d = pos_q + {9'd0, rem};
              if (pos_d == tl_q) begin
                mode_d = lin_dtl_pkg::MODE_IDLE;
                armed_d = 1'b0;
                done_d = 1'b1;
                dnad_d = nad;
              end else begin
                seq_d = seq_q + 4'd1;
                armed_d = 1'b1;
                to_d = rx_to_q;
              end
            end
          end
        end
      end
      lin_dtl_pkg::REQ_LOAD: begin
        if (mode_q == lin_dtl_pkg::MODE_IDLE) begin
          wr_d = 1'b1;
          cnt_d = 3'd1;
          base_d = {1'b0, bidx_q};
          wsh_d = {56'd0, rbyte_q};
          if (rlast_q && rlen_q <= DEPTH12) begin
            pos_d = 12'd0;
            tl_d = rlen_q;
            armed_d = 1'b1;
            to_d = rx_to_q;
            mode_d = (rlen_q > SF12) ? lin_dtl_pkg::MODE_SEND_FF : lin_dtl_pkg::MODE_SEND_SF;
          end
        end
      end
      lin_dtl_pkg::REQ_TX_SLOT: begin
        if (mode_q == lin_dtl_pkg::MODE_SEND_SF) begin
          txf_d[7:0] = resp_nad_q;
          txf_d[15:8] = {lin_dtl_pkg::PCI_SINGLE, sf_len[3:0]};
          rd_d = 1'b1;
          cnt_d = sf_len[2:0];
          mode_d = lin_dtl_pkg::MODE_IDLE;
          armed_d = 1'b0;
          txv_d = 1'b1;
        end else if (mode_q == lin_dtl_pkg::MODE_SEND_FF) begin
          txf_d[7:0] = cfg_nad_q;
          txf_d[15:8] = {lin_dtl_pkg::PCI_FIRST, tl_q[11:8]};
          txf_d[23:16] = tl_q[7:0];
          rd_d = 1'b1;
          cnt_d = 3'(lin_dtl_pkg::FF_BYTES);
          slot_d = 3'd3;
          pos_d = 12'(lin_dtl_pkg::FF_BYTES);
          seq_d = 4'd1;
          mode_d = lin_dtl_pkg::MODE_SEND_CF;
          armed_d = 1'b1;
          to_d = rx_to_q;
          sep_d = sep_time_q;
          txv_d = 1'b1;
        end else if (mode_q == lin_dtl_pkg::MODE_SEND_CF && sep_q == 8'd0) begin
          txf_d[7:0] = cfg_nad_q;
          txf_d[15:8] = {lin_dtl_pkg::PCI_CONSEC, seq_q};
          rd_d = 1'b1;
          cnt_d = rem;
          base_d = {1'b0, pos_q};
          seq_d = seq_q + 4'd1;
          pos_d = pos_q + {9'd0, rem};
          if (pos_d >= tl_q) begin
            mode_d = lin_dtl_pkg::MODE_IDLE;
            armed_d = 1'b0;
          end else begin
            armed_d = 1'b1;
            to_d = rx_to_q;
            sep_d = sep_time_q;
          end
          txv_d = 1'b1;
        end
      end
      lin_dtl_pkg::REQ_TICK: begin
        if (armed_q) begin
          to_d = to_dec;
          if (to_dec == 16'd0) begin
            lay_rst = 1'b1;
            ab_d = 1'b1;
          end
        end
      end
      lin_dtl_pkg::REQ_READ: begin
        rd_d = 1'b1;
        host_d = 1'b1;
        cnt_d = 3'd1;
        base_d = {1'b0, bidx_q};
      end
      default: begin
      end
    endcase
    if (lay_rst) begin
      mode_d = lin_dtl_pkg::MODE_IDLE;
      pos_d = 12'd0;
      tl_d = 12'd0;
      seq_d = 4'd0;
      to_d = 16'd0;
      armed_d = 1'b0;
      sep_d = sep_time_q;
      sep_base = sep_time_q;
    end
    if (req_q == lin_dtl_pkg::REQ_TICK && sep_base != 8'd0) begin
      sep_d = sep_base - 8'd1;
    end
  end

  assign addr = base_q + {10'd0, k_q};
  assign inr = (addr < DEPTH13);
  assign step = (state_q == S_MOVE) && (k_q != cnt_q);
  assign mem_we = step && wr_q && inr;
  assign mem_re = step && rd_q && inr;

  lin_dtl_mem #(
    .DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_mem (
    .clk_i(clk_i),
    .we_i(mem_we),
    .waddr_i(addr[AW-1:0]),
    .wdata_i(wsh_q[7:0]),
    .re_i(mem_re),
    .raddr_i(addr[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_nad_q <= lin_dtl_pkg::RST_NAD;
      init_nad_q <= lin_dtl_pkg::RST_NAD;
      resp_nad_q <= lin_dtl_pkg::RST_NAD;
      rx_to_q <= lin_dtl_pkg::RST_TIMEOUT;
      sep_time_q <= 8'd0;
      mode_q <= lin_dtl_pkg::MODE_IDLE;
      pos_q <= 12'd0;
      tl_q <= 12'd0;
      seq_q <= 4'd0;
      to_q <= 16'd0;
      armed_q <= 1'b0;
      sep_q <= 8'd0;
      k_q <= 3'd0;
      rv_q <= 1'b0;
      rsp_o.valid <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          lin_dtl_pkg::CFG_CONFIGURED_NAD: cfg_nad_q <= cfg_i.data[7:0];
          lin_dtl_pkg::CFG_INITIAL_NAD: init_nad_q <= cfg_i.data[7:0];
          lin_dtl_pkg::CFG_RESPONSE_NAD: resp_nad_q <= cfg_i.data[7:0];
          lin_dtl_pkg::CFG_RX_TIMEOUT: rx_to_q <= cfg_i.data;
          lin_dtl_pkg::CFG_SEP_TIME: sep_time_q <= cfg_i.data[7:0];
          default: begin
          end
        endcase
      end
      if (rsp_o.valid && rsp_o.ready && state_q != S_DONE) begin
        rsp_o.valid <= 1'b0;
      end
      rv_q <= mem_re;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q <= req_i.req_type;
            frame_q <= req_i.frame;
            rbyte_q <= req_i.resp_byte;
            bidx_q <= req_i.byte_index;
            rlen_q <= req_i.resp_length;
            rlast_q <= req_i.resp_last;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          mode_q <= mode_d;
          pos_q <= pos_d;
          tl_q <= tl_d;
          seq_q <= seq_d;
          to_q <= to_d;
          armed_q <= armed_d;
          sep_q <= sep_d;
          wr_q <= wr_d;
          rd_q <= rd_d;
          host_q <= host_d;
          cnt_q <= cnt_d;
          base_q <= base_d;
          wsh_q <= wsh_d;
          slot_q <= slot_d;
          txv_q <= txv_d;
          txf_q <= txf_d;
          done_q <= done_d;
          dnad_q <= dnad_d;
          ab_q <= ab_d;
          rdb_q <= 8'd0;
          k_q <= 3'd0;
          state_q <= S_MOVE;
        end
        S_MOVE: begin
          if (step) begin
            k_q <= k_q + 3'd1;
            wsh_q <= wsh_q >> 8;
            slot_q <= slot_q + 3'd1;
            rslot_q <= slot_q;
          end
          if (rv_q) begin
            if (host_q) begin
              rdb_q <= mem_rdata;
            end else begin
              txf_q[8*rslot_q +: 8] <= mem_rdata;
            end
          end
          if (!step && !rv_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_o.valid || rsp_o.ready) begin
            rsp_o.valid <= 1'b1;
            rsp_o.tx_valid <= txv_q;
            rsp_o.tx_frame <= txv_q ? txf_q : 64'd0;
            rsp_o.msg_complete <= done_q;
            rsp_o.msg_nad <= dnad_q;
            rsp_o.msg_length <= tl_q;
            rsp_o.read_byte <= rdb_q;
            rsp_o.tl_mode <= mode_q;
            rsp_o.aborted <= ab_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/lin_dtl_checker.sv
// Checker: port-level assertions for the LIN diagnostic transport layer
`timescale 1ns / 1ps
`include "lin_diag_transport_layer_unit_defines.svh"
module lin_dtl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        tx_valid_i,
  input logic        msg_complete_i,
  input logic        aborted_i,
  input logic [2:0]  tl_mode_i,
  input logic [11:0] msg_length_i
);
  `LDT_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result beat dropped")
  `LDT_ASSERT(a_tx_mode, rsp_valid_i && tx_valid_i, tl_mode_i == lin_dtl_pkg::MODE_IDLE || tl_mode_i == lin_dtl_pkg::MODE_SEND_CF, "bad mode after transmit")
  `LDT_ASSERT(a_done_idle, rsp_valid_i && msg_complete_i, tl_mode_i == lin_dtl_pkg::MODE_IDLE && !tx_valid_i && !aborted_i, "bad completion")
  `LDT_ASSERT(a_abort_clr, rsp_valid_i && aborted_i, tl_mode_i == lin_dtl_pkg::MODE_IDLE && msg_length_i == 12'd0, "abort left state")
endmodule

bind lin_diag_transport_layer_unit lin_dtl_checker u_lin_dtl_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .tx_valid_i(rsp_o.tx_valid),
  .msg_complete_i(rsp_o.msg_complete),
  .aborted_i(rsp_o.aborted),
  .tl_mode_i(rsp_o.tl_mode),
  .msg_length_i(rsp_o.msg_length)
);

### bench/lin_diag_transport_layer_unit_tb.sv
// Testbench: LIN transport layer unit checked beat by beat against an inline layer model
`timescale 1ns / 1ps
module lin_diag_transport_layer_unit_tb;
  import lin_dtl_pkg::*;

  localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 1250;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] frame;
    logic [7:0]  rbyte;
    logic [11:0] idx;
    logic [11:0] rlen;
    logic        rlast;
  } lin_req_t;

  typedef struct {
    logic        tx_valid;
    logic [63:0] tx_frame;
    logic        done;
    logic [7:0]  nad;
    logic [11:0] length;
    logic [7:0]  rd;
    logic [2:0]  tl_mode;
    logic        aborted;
  } lin_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lin_dtl_req_if req_if ();
  lin_dtl_rsp_if rsp_if ();
  lin_dtl_cfg_if cfg_if ();

  lin_diag_transport_layer_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // layer model state
  logic [7:0]  cfg_nad, init_nad, resp_nad, sep_time;
  logic [15:0] rx_timeout;
  logic [7:0]  lbuf [DEPTH];
  mode_e       lmode;
  logic [11:0] lpos, ltotal;
  logic [3:0]  lseq;
  logic [15:0] tmo_cnt;
  logic        tmo_armed;
  logic [7:0]  sep_cnt;

  lin_req_t req_pend_q[$];
  lin_rsp_t due_rsp_q[$];
  lin_req_t cur;
  bit       has_cur;
  int       gap_left, burst_left;
  int       errors;
  int       n_items;
  int       hold_trig, hold_seen, hold_left, stretch_left;
  bit       stall_on;
  int unsigned cycles;

  function automatic void layer_clear();
    lmode = MODE_IDLE;
    lpos = '0;
    ltotal = '0;
    lseq = '0;
    tmo_cnt = '0;
    tmo_armed = 1'b0;
    sep_cnt = sep_time;
  endfunction

  function automatic void arm();
    tmo_armed = 1'b1;
    tmo_cnt = rx_timeout;
  endfunction

  function automatic logic [7:0] buf_rd(int unsigned a);
    return (a < DEPTH) ? lbuf[a] : 8'h00;
  endfunction

  function automatic void buf_wr(int unsigned a, logic [7:0] v);
    if (a < DEPTH) lbuf[a] = v;
  endfunction

  function automatic lin_rsp_t layer_step(lin_req_t it);
    lin_rsp_t r;
    logic [7:0] nad, b1;
    logic [7:0] tb [8];
    int unsigned len, rem;
    r = '{default: '0};
    nad = it.frame[7:0];
    b1 = it.frame[15:8];
    for (int k = 0; k < 8; k++) tb[k] = 8'hFF;
    case (it.kind)
      REQ_RX_FRAME: begin
        if (nad != NAD_BROADCAST && nad != NAD_FUNCTIONAL && nad != cfg_nad &&
            nad != init_nad) begin
          layer_clear();
          r.aborted = 1'b1;
        end else if (lmode != MODE_IDLE && nad == NAD_FUNCTIONAL) begin
          arm();
        end else if (b1[7:4] == PCI_SINGLE) begin
          len = b1[3:0];
          if (len >= 1 && len <= SF_MAX) begin
            for (int k = 0; k < len; k++) buf_wr(k, it.frame[8*(2+k) +: 8]);
            ltotal = 12'(len);
            lmode = MODE_IDLE;
            tmo_armed = 1'b0;
            r.done = 1'b1;
            r.nad = nad;
          end
        end else if (b1[7:4] == PCI_FIRST) begin
          len = {b1[3:0], it.frame[23:16]};
          if (len > SF_MAX && len <= DEPTH) begin
            ltotal = 12'(len);
            for (int k = 0; k < FF_BYTES; k++) buf_wr(k, it.frame[8*(3+k) +: 8]);
            lpos = 12'(FF_BYTES);
            lseq = 4'd1;
            lmode = MODE_WAIT_CF;
            arm();
          end
        end else if (b1[7:4] == PCI_CONSEC) begin
          if (lmode == MODE_WAIT_CF) begin
            rem = (ltotal > lpos) ? ltotal - lpos : 0;
            if (rem > SF_MAX) rem = SF_MAX;
            if (b1[3:0] != lseq) begin
              layer_clear();
              r.aborted = 1'b1;
            end else begin
              for (int k = 0; k < rem; k++) buf_wr(lpos + k, it.frame[8*(2+k) +: 8]);
              lpos = 12'(lpos + rem);
              if (lpos == ltotal) begin
                lmode = MODE_IDLE;
                tmo_armed = 1'b0;
                r.done = 1'b1;
                r.nad = nad;
              end else begin
                lseq = lseq + 4'd1;
                arm();
              end
            end
          end
        end
      end
      REQ_LOAD: begin
        if (lmode == MODE_IDLE) begin
          buf_wr(it.idx, it.rbyte);
          if (it.rlast && it.rlen <= DEPTH) begin
            lpos = '0;
            ltotal = it.rlen;
            arm();
            lmode = (it.rlen > SF_MAX) ? MODE_SEND_FF : MODE_SEND_SF;
          end
        end
      end
      REQ_TX_SLOT: begin
        if (lmode == MODE_SEND_SF) begin
          len = (ltotal > SF_MAX) ? SF_MAX : ltotal;
          tb[0] = resp_nad;
          tb[1] = {PCI_SINGLE, 4'(len)};
          for (int k = 0; k < len; k++) tb[2+k] = buf_rd(k);
          lmode = MODE_IDLE;
          tmo_armed = 1'b0;
          r.tx_valid = 1'b1;
        end else if (lmode == MODE_SEND_FF) begin
          tb[0] = cfg_nad;
          tb[1] = {PCI_FIRST, ltotal[11:8]};
          tb[2] = ltotal[7:0];
          for (int k = 0; k < FF_BYTES; k++) tb[3+k] = buf_rd(k);
          lpos = 12'(FF_BYTES);
          lseq = 4'd1;
          lmode = MODE_SEND_CF;
          arm();
          sep_cnt = sep_time;
          r.tx_valid = 1'b1;
        end else if (lmode == MODE_SEND_CF && sep_cnt == 0) begin
          rem = (ltotal > lpos) ? ltotal - lpos : 0;
          if (rem > SF_MAX) rem = SF_MAX;
          tb[0] = cfg_nad;
          tb[1] = {PCI_CONSEC, lseq};
          for (int k = 0; k < rem; k++) tb[2+k] = buf_rd(lpos + k);
          lseq = lseq + 4'd1;
          lpos = 12'(lpos + rem);
          if (lpos >= ltotal) begin
            lmode = MODE_IDLE;
            tmo_armed = 1'b0;
          end else begin
            arm();
            sep_cnt = sep_time;
          end
          r.tx_valid = 1'b1;
        end
        if (r.tx_valid)
          for (int k = 0; k < 8; k++) r.tx_frame[8*k +: 8] = tb[k];
      end
      REQ_TICK: begin
        if (tmo_armed) begin
          tmo_cnt = tmo_cnt - 16'd1;
          if (tmo_cnt == 0) begin
            layer_clear();
            r.aborted = 1'b1;
          end
        end
        if (sep_cnt > 0) sep_cnt = sep_cnt - 8'd1;
      end
      REQ_READ: r.rd = buf_rd(it.idx);
      default: ;
    endcase
    r.length = ltotal;
    r.tl_mode = lmode;
    return r;
  endfunction

  // stimulus builders
  function automatic void push_req(logic [2:0] kind, logic [63:0] f, logic [7:0] b,
                                   logic [11:0] idx, logic [11:0] len, logic last);
    lin_req_t it;
    it.kind = kind;
    it.frame = f;
    it.rbyte = b;
    it.idx = idx;
    it.rlen = len;
    it.rlast = last;
    req_pend_q.push_back(it);
    n_items++;
  endfunction

  function automatic void push_rx(logic [7:0] nad, logic [7:0] b1, logic [7:0] b2 = 8'h00,
                                  bit keep_b2 = 1'b0);
    logic [63:0] f;
    f = {$urandom, $urandom};
    f[7:0] = nad;
    f[15:8] = b1;
    if (keep_b2) f[23:16] = b2;
    push_req(REQ_RX_FRAME, f, 8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
  endfunction

  function automatic void push_op(logic [2:0] kind, logic [11:0] idx = 12'd0);
    push_req(kind, {$urandom, $urandom}, 8'($urandom), idx, 12'($urandom), 1'($urandom));
  endfunction

  function automatic void push_load(logic [11:0] idx, logic [11:0] len, logic last);
    push_req(REQ_LOAD, {$urandom, $urandom}, 8'($urandom), idx, len, last);
  endfunction

  function automatic logic [7:0] pick_nad();
    case ($urandom_range(0, 19))
      0, 1, 2: return NAD_BROADCAST;
      3, 4: return NAD_FUNCTIONAL;
      5, 6, 7: return init_nad;
      8: return 8'($urandom);
      default: return cfg_nad;
    endcase
  endfunction

  function automatic void gen_first_frame();
    int unsigned len, ncf;
    logic [3:0] sq;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(7, DEPTH);
      1: len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 6) : $urandom_range(257, 4095);
      default: len = $urandom_range(7, 40);
    endcase
    push_rx(pick_nad(), {PCI_FIRST, 4'(len >> 8)}, 8'(len), 1'b1);
    ncf = (len > SF_MAX && len <= DEPTH) ? (len - FF_BYTES + 5) / 6 : $urandom_range(0, 2);
    for (int k = 0; k < ncf; k++) begin
      if ($urandom_range(0, 4) == 0) push_op(REQ_TICK);
      sq = 4'(k + 1);
      if ($urandom_range(0, 39) == 0) sq = sq ^ 4'($urandom_range(1, 15));
      push_rx(($urandom_range(0, 9) == 0) ? pick_nad() : cfg_nad, {PCI_CONSEC, sq});
    end
  endfunction

  function automatic void gen_response();
    int unsigned len, nld, nfr;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(31, DEPTH);
      1: len = $urandom_range(257, 4095);
      default: len = $urandom_range(0, 30);
    endcase
    nld = (len == 0) ? 1 : (len > DEPTH ? $urandom_range(1, 8) : len);
    for (int k = 0; k < nld; k++)
      push_load((len == 0) ? 12'($urandom_range(0, DEPTH - 1)) : 12'(k), 12'(len),
                k == nld - 1);
    nfr = (len > SF_MAX) ? 1 + (len - FF_BYTES + 5) / 6 : 1;
    for (int k = 0; k < nfr + $urandom_range(0, 1); k++) begin
      if (k > 0) repeat ($urandom_range(0, (sep_time > 3) ? 3 : sep_time)) push_op(REQ_TICK);
      push_op(REQ_TX_SLOT);
    end
  endfunction

  function automatic void gen_random_seq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      push_rx(pick_nad(), {PCI_SINGLE, ($urandom_range(0, 7) == 0) ?
              4'($urandom_range(0, 15)) : 4'($urandom_range(1, 6))});
    end else if (r < 40) gen_first_frame();
    else if (r < 60) gen_response();
    else if (r < 70) repeat ($urandom_range(1, 8)) push_op(REQ_TICK);
    else if (r < 80) begin
      push_op(REQ_READ, ($urandom_range(0, 5) == 0) ? 12'($urandom) :
              12'($urandom_range(0, DEPTH - 1)));
    end else begin
      push_req(3'($urandom_range(0, 7)), {$urandom, $urandom}, 8'($urandom), 12'($urandom),
               12'($urandom), 1'($urandom));
    end
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.req_type <= '0;
      req_if.frame <= '0;
      req_if.resp_byte <= '0;
      req_if.byte_index <= '0;
      req_if.resp_length <= '0;
      req_if.resp_last <= 1'b0;
      has_cur = 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_rsp_q.push_back(layer_step(cur));
        has_cur = 1'b0;
      end
      if (!has_cur) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pend_q.size() > 0) begin
          cur = req_pend_q.pop_front();
          has_cur = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 20);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      req_if.valid <= has_cur;
      if (has_cur) begin
        req_if.req_type <= cur.kind;
        req_if.frame <= cur.frame;
        req_if.resp_byte <= cur.rbyte;
        req_if.byte_index <= cur.idx;
        req_if.resp_length <= cur.rlen;
        req_if.resp_last <= cur.rlast;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      stretch_left = 0;
      stall_on = 1'b0;
    end else begin
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = 400;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(10, 80);
        stall_on = $urandom_range(0, 2) != 0;
      end
      stretch_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    lin_rsp_t w;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_rsp_q.size() == 0) begin
        report("unexpected beat", 64'(rsp_if.tl_mode), 64'd0);
      end else begin
        w = due_rsp_q.pop_front();
        if (rsp_if.tx_valid !== w.tx_valid)
          report("tx_valid", 64'(rsp_if.tx_valid), 64'(w.tx_valid));
        if (rsp_if.tx_frame !== w.tx_frame) report("tx_frame", rsp_if.tx_frame, w.tx_frame);
        if (rsp_if.msg_complete !== w.done)
          report("msg_complete", 64'(rsp_if.msg_complete), 64'(w.done));
        if (rsp_if.msg_nad !== w.nad) report("msg_nad", 64'(rsp_if.msg_nad), 64'(w.nad));
        if (rsp_if.msg_length !== w.length)
          report("msg_length", 64'(rsp_if.msg_length), 64'(w.length));
        if (rsp_if.read_byte !== w.rd) report("read_byte", 64'(rsp_if.read_byte), 64'(w.rd));
        if (rsp_if.tl_mode !== w.tl_mode)
          report("tl_mode", 64'(rsp_if.tl_mode), 64'(w.tl_mode));
        if (rsp_if.aborted !== w.aborted)
          report("aborted", 64'(rsp_if.aborted), 64'(w.aborted));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_CONFIGURED_NAD: cfg_nad = v[7:0];
      CFG_INITIAL_NAD: init_nad = v[7:0];
      CFG_RESPONSE_NAD: resp_nad = v[7:0];
      CFG_RX_TIMEOUT: rx_timeout = v;
      CFG_SEP_TIME: sep_time = v[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (req_pend_q.size() > 0 || has_cur || due_rsp_q.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] cn, logic [7:0] in, logic [7:0] rn,
                           logic [15:0] tmo, logic [7:0] sep, int unsigned upto,
                           bit long_hold);
    cfg_write(CFG_CONFIGURED_NAD, cn);
    cfg_write(CFG_INITIAL_NAD, in);
    cfg_write(CFG_RESPONSE_NAD, rn);
    cfg_write(CFG_RX_TIMEOUT, tmo);
    cfg_write(CFG_SEP_TIME, sep);
    while (n_items < upto) gen_random_seq();
    if (long_hold) hold_trig++;
    drain();
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    errors = 0;
    n_items = 0;
    hold_trig = 0;
    cycles = 0;
    cfg_nad = RST_NAD;
    init_nad = RST_NAD;
    resp_nad = RST_NAD;
    rx_timeout = RST_TIMEOUT;
    sep_time = 8'd0;
    layer_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the buffer so that no later read hits an unwritten byte
    for (int k = 0; k < DEPTH; k++) push_load(12'(k), 12'($urandom), 1'b0);

    push_rx(NAD_BROADCAST, {PCI_SINGLE, 4'd6});
    push_rx(RST_NAD, {PCI_SINGLE, 4'd0});
    push_rx(RST_NAD, {PCI_SINGLE, 4'd7});
    push_rx(RST_NAD, {PCI_FIRST, 4'd0}, 8'd6, 1'b1);
    push_rx(RST_NAD, {PCI_FIRST, 4'd1}, 8'd1, 1'b1);
    push_rx(RST_NAD, {PCI_CONSEC, 4'd1});
    push_rx(RST_NAD, {PCI_FIRST, 4'd0}, 8'd8, 1'b1);
    push_rx(NAD_FUNCTIONAL, {PCI_SINGLE, 4'd3});
    push_load(12'd0, 12'd3, 1'b1);
    push_rx(RST_NAD, {PCI_CONSEC, 4'd1});
    push_rx(RST_NAD, {PCI_FIRST, 4'd0}, 8'd20, 1'b1);
    push_rx(RST_NAD, {PCI_CONSEC, 4'd5});
    push_rx(8'h55, {PCI_SINGLE, 4'd2});
    push_rx(RST_NAD, 8'h35);
    push_load(12'd4095, 12'd0, 1'b0);
    push_load(12'd7, 12'd257, 1'b1);
    push_load(12'd3, 12'd0, 1'b1);
    push_load(12'd4, 12'd5, 1'b1);
    push_op(REQ_TX_SLOT);
    push_op(REQ_TX_SLOT);
    push_load(12'd9, 12'd9, 1'b1);
    push_op(REQ_TX_SLOT);
    push_op(REQ_TICK);
    push_op(REQ_TX_SLOT);
    push_op(REQ_READ, 12'd0);
    push_op(REQ_READ, 12'd4095);
    push_op(3'd7);
    drain();

    run_phase(8'h10, 8'h20, 8'h33, 16'd5, 8'd2, 450, 1'b1);
    run_phase(8'h00, 8'hFF, 8'hFF, 16'd1, 8'd0, 750, 1'b0);
    run_phase(8'hFF, 8'h00, 8'h80, 16'd65535, 8'd255, 1000, 1'b1);
    run_phase(8'h22, 8'h7F, 8'h00, 16'd20, 8'd1, ITEM_TARGET, 1'b0);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
